>>> src/alir_pkg.sv
// Shared types and constants for the shifting array list.
package alir_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_e;

  // Broadcast command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } cell_op_t;

endpackage

>>> src/alir_cell.sv
// One entry of the list chain: holds a word and takes it from a neighbour on shifts.
module alir_cell #(
  parameter int unsigned CntW = 7,
  parameter int unsigned Pos  = 0
) (
  input  logic                                clk_i,
  input  alir_pkg::cell_op_t                  op_i,
  input  logic [CntW-1:0]                     idx_i,
  input  logic signed [alir_pkg::DataW-1:0]   value_i,
  input  logic signed [alir_pkg::DataW-1:0]   left_i,
  input  logic signed [alir_pkg::DataW-1:0]   right_i,
  output logic signed [alir_pkg::DataW-1:0]   data_o
);
  import alir_pkg::*;

  localparam logic [CntW-1:0] PosC = CntW'(Pos);

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    at_idx, above_idx;

  assign at_idx    = (idx_i == PosC);
  assign above_idx = (PosC > idx_i);

  // Pick the next word: own, neighbour or new value
  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (above_idx) begin
        entry_d = left_i;
      end else if (at_idx) begin
        entry_d = value_i;
      end
    end else if (op_i.rem) begin
      if (above_idx || at_idx) begin
        entry_d = right_i;
      end
    end else if (op_i.wr && at_idx) begin
      entry_d = value_i;
    end
  end

  // Hold the word; no reset on payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;

endmodule

>>> src/alir_outbuf.sv
// Two-slot result buffer: output register plus skid slot.
module alir_outbuf #(
  parameter int unsigned Width = 42
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [Width-1:0] data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Width-1:0] data_o
);

  logic             head_valid_q, head_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [Width-1:0] head_q, head_d;
  logic [Width-1:0] skid_q, skid_d;
  logic             push, pop;

  assign in_stall_o = skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = head_valid_q && !out_stall_i;

  // Advance skid into head when head frees up, else park the new request
  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (!head_valid_q || pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        head_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        head_d       = data_i;
        head_valid_d = push;
      end
    end else if (push) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = head_valid_q;
  assign data_o      = head_q;

endmodule

>>> src/array_list_insert_remove.sv
// Top level of the shifting array list: fill counter, cell chain and result buffer.
// A request's result is registered in the output register, or in the skid slot if it is held.
// Throughput: one request per cycle unless stalled; every cell shifts at once, so the chain
// updates whole on each request. A two-slot result buffer keeps requests flowing under stall.
// Reset clears the fill count and the buffer; entry words stay undefined until written
// and need no clearing pass.
module array_list_insert_remove #(
  parameter int unsigned  DEPTH = 64,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [alir_pkg::OpW-1:0]            opcode_i,
  input  logic [CntW-1:0]                     index_i,
  input  logic signed [alir_pkg::DataW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [alir_pkg::DataW-1:0]   read_value_o,
  output logic [CntW-1:0]                     count_o,
  output logic                                is_empty_o,
  output logic [alir_pkg::StW-1:0]            status_o
);
  import alir_pkg::*;

  localparam int unsigned    IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned    ResW  = DataW + CntW + 1 + StW;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic                    accept;
  logic [CntW-1:0]         fill_q, fill_d;
  cell_op_t                cell_op;
  st_e                     status;
  logic signed [DataW-1:0] rd_value;
  logic signed [DataW-1:0] data_w [DEPTH];
  logic [ResW-1:0]         res_in, res_out;

  assign accept = in_valid_i && !in_stall_o;

  // Decode the request against the current length
  always_comb begin
    fill_d   = fill_q;
    cell_op  = '0;
    status   = ST_OK;
    rd_value = '0;
    case (op_e'(opcode_i))
      OP_INSERT: begin
        if (index_i > fill_q) begin
          status = ST_RANGE;
        end else if (fill_q == DepthC) begin
          status = ST_FULL;
        end else begin
          cell_op.ins = accept;
          fill_d      = fill_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (index_i >= fill_q) begin
          status = ST_RANGE;
        end else begin
          cell_op.rem = accept;
          fill_d      = fill_q - CntW'(1);
        end
      end
      OP_READ: begin
        if (index_i >= fill_q) begin
          status = ST_RANGE;
        end else begin
          rd_value = data_w[index_i[IdxW-1:0]];
        end
      end
      OP_WRITE: begin
        if (index_i >= fill_q) begin
          status = ST_RANGE;
        end else begin
          cell_op.wr = accept;
        end
      end
      OP_CLEAR: begin
        fill_d = '0;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  // Track the list length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  // Chain of entry cells, each wired to its neighbours
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = data_w[k];
    end else begin : g_left
      assign left_w = data_w[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = data_w[k];
    end else begin : g_right
      assign right_w = data_w[k+1];
    end
    alir_cell #(
      .CntW (CntW),
      .Pos  (k)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .idx_i   (index_i),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[k])
    );
  end

  // Pack the result and hand it to the buffer
  assign res_in = {rd_value, fill_d, (fill_d == '0), status};

  alir_outbuf #(
    .Width (ResW)
  ) u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_i      (res_in),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_out)
  );

  assign read_value_o = res_out[ResW-1 -: DataW];
  assign count_o      = res_out[StW+1 +: CntW];
  assign is_empty_o   = res_out[StW];
  assign status_o     = res_out[StW-1:0];

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthC)
    else $error("list length exceeds capacity");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (read_value_o == '0))
    else $error("refused request returned data");

  a_read_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_READ || opcode_i == OP_WRITE)) |=> $stable(fill_q))
    else $error("read or write changed the length");

  a_stall_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stalled with empty output register");

endmodule
